[src/sshf_pkg.sv]
// Shared types and constants of the single strip hit finder.
package sshf_pkg;

    localparam int TIME_W   = 32;
    localparam int MODULE_W = 3;
    localparam int STRIP_W  = 8;
    localparam int CFG_IDX_W = 2;

    // No-hit floor: -999999 ns with 8 fraction bits.
    localparam logic signed [TIME_W-1:0] NO_HIT_FLOOR = -32'sd255999744;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_MODULE  = 2'd2;

    // Operand pairs of the shared comparator; result is a > b.
    typedef enum logic [1:0] {
        CMP_UPPER_LOWER = 2'd0,
        CMP_TIME_LOWER  = 2'd1,
        CMP_UPPER_TIME  = 2'd2,
        CMP_TIME_FLOOR  = 2'd3
    } cmp_sel_t;

endpackage

[src/sshf_ifs.sv]
// Handshake interfaces of the hit input, result output and config write words.
interface sshf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic [sshf_pkg::MODULE_W-1:0]         module_id;
    logic [sshf_pkg::STRIP_W-1:0]          strip_id;
    logic                                  first_of_channel;
    logic signed [sshf_pkg::TIME_W-1:0]    hit_time;

    modport source (output valid, func, module_id, strip_id, first_of_channel, hit_time,
                    input ready);
    modport sink   (input valid, func, module_id, strip_id, first_of_channel, hit_time,
                    output ready);
endinterface

interface sshf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [sshf_pkg::STRIP_W-1:0]          found_strip;
    logic signed [sshf_pkg::TIME_W-1:0]    found_time;

    modport source (output valid, found, found_strip, found_time, input ready);
    modport sink   (input valid, found, found_strip, found_time, output ready);
endinterface

interface sshf_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [sshf_pkg::CFG_IDX_W-1:0]        index;
    logic [sshf_pkg::TIME_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/sshf_cmp_unit.sv]
// Shared signed comparator with operand selection.
module sshf_cmp_unit (
    input  sshf_pkg::cmp_sel_t                 sel,
    input  logic signed [sshf_pkg::TIME_W-1:0] lower_bound,
    input  logic signed [sshf_pkg::TIME_W-1:0] upper_bound,
    input  logic signed [sshf_pkg::TIME_W-1:0] hit_time,
    output logic                               gt
);

    logic signed [sshf_pkg::TIME_W-1:0] op_a;
    logic signed [sshf_pkg::TIME_W-1:0] op_b;

    always_comb
    begin
        unique case (sel)
            sshf_pkg::CMP_UPPER_LOWER:
            begin
                op_a = upper_bound;
                op_b = lower_bound;
            end
            sshf_pkg::CMP_TIME_LOWER:
            begin
                op_a = hit_time;
                op_b = lower_bound;
            end
            sshf_pkg::CMP_UPPER_TIME:
            begin
                op_a = upper_bound;
                op_b = hit_time;
            end
            sshf_pkg::CMP_TIME_FLOOR:
            begin
                op_a = hit_time;
                op_b = sshf_pkg::NO_HIT_FLOOR;
            end
            default:
            begin
                op_a = hit_time;
                op_b = sshf_pkg::NO_HIT_FLOOR;
            end
        endcase
    end

    assign gt = (op_a > op_b);

endmodule

[src/single_strip_hit_finder_unit.sv]
// Top level of the single strip hit finder: sequencer, hit map, time store, result register.
//
//  channel   | dir | fields                                              | word meaning
//  ----------+-----+-----------------------------------------------------+----------------------
//  hit_in    | in  | func, module_id, strip_id, first_of_channel,        | one time or
//            |     | hit_time                                            | end of event
//  result_out| out | found, found_strip, found_time                      | one per end of event
//  cfg       | in  | index, data                                         | register write
//
// A time word of another module, or of an already consumed record, is accepted and dropped.
// A candidate time takes at most these steps (accept, then window-enable, lower, upper and
// floor compares, all on the one shared comparator). For an end-of-event word
// the hit map is scanned one strip a cycle, then the time store
// is read (registered read) and the result loaded.
// Reset clears the hit map, the record flag, the config registers and the sequencer.
// hit_in is ready only while the sequencer is idle. Beyond the steps above, it stalls
// only when a new result is ready and the previous one has not yet been taken.
// cfg is always ready.
module single_strip_hit_finder_unit #(
    parameter int CHANNELS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    sshf_in_if.sink        hit_in,
    sshf_out_if.source     result_out,
    sshf_cfg_if.sink       cfg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_CMP_WIN   = 8'b0000_0010,
        ST_CMP_LO    = 8'b0000_0100,
        ST_CMP_HI    = 8'b0000_1000,
        ST_CMP_FLOOR = 8'b0001_0000,
        ST_SCAN      = 8'b0010_0000,
        ST_READ      = 8'b0100_0000,
        ST_EMIT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Config registers
    logic signed [sshf_pkg::TIME_W-1:0]   lower_bound_reg;
    logic signed [sshf_pkg::TIME_W-1:0]   upper_bound_reg;
    logic [sshf_pkg::MODULE_W-1:0]        use_module_reg;

    // Latched item
    logic [sshf_pkg::STRIP_W-1:0]         strip_reg;
    logic signed [sshf_pkg::TIME_W-1:0]   time_reg;

    // Record and event state
    logic                                 taken_reg, taken_next;
    logic [CHANNELS-1:0]                  hit_map_reg;
    logic signed [sshf_pkg::TIME_W-1:0]   strip_mem [CHANNELS];
    logic signed [sshf_pkg::TIME_W-1:0]   rd_data_reg;

    // Scan state
    logic [IDX_W-1:0]                     scan_idx_reg;
    logic [1:0]                           hit_cnt_reg;
    logic [IDX_W-1:0]                     hit_idx_reg;

    // Result register
    logic                                 out_valid_reg;
    logic                                 out_found_reg;
    logic [sshf_pkg::STRIP_W-1:0]         out_strip_reg;
    logic signed [sshf_pkg::TIME_W-1:0]   out_time_reg;

    sshf_pkg::cmp_sel_t                   cmp_sel;
    logic                                 cmp_gt;
    logic                                 in_accept;
    logic                                 taken_eff;
    logic                                 strip_ok;
    logic                                 store_en;
    logic                                 scan_last;
    logic                                 clear_map;
    logic                                 load_out;

    assign hit_in.ready = (state_reg == ST_IDLE);
    assign in_accept    = hit_in.valid && hit_in.ready;
    assign cfg.ready    = 1'b1;

    // A new record start drops the consumed flag before the check.
    assign taken_eff = hit_in.first_of_channel ? 1'b0 : taken_reg;
    assign strip_ok  = ({1'b0, strip_reg} < 9'(CHANNELS));
    assign scan_last = ({1'b0, scan_idx_reg} == (IDX_W + 1)'(CHANNELS - 1));

    sshf_cmp_unit u_cmp (
        .sel         (cmp_sel),
        .lower_bound (lower_bound_reg),
        .upper_bound (upper_bound_reg),
        .hit_time    (time_reg),
        .gt          (cmp_gt)
    );

    // Operand pair for each compare step
    always_comb
    begin
        unique case (state_reg)
            ST_CMP_WIN: cmp_sel = sshf_pkg::CMP_UPPER_LOWER;
            ST_CMP_LO:  cmp_sel = sshf_pkg::CMP_TIME_LOWER;
            ST_CMP_HI:  cmp_sel = sshf_pkg::CMP_UPPER_TIME;
            default:    cmp_sel = sshf_pkg::CMP_TIME_FLOOR;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        taken_next = taken_reg;
        store_en   = 1'b0;
        clear_map  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (hit_in.func)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        taken_next = taken_eff;
                        if (hit_in.module_id == use_module_reg && !taken_eff)
                        begin
                            state_next = ST_CMP_WIN;
                        end
                    end
                end
            end
            ST_CMP_WIN:
            begin
                // Window is only applied when upper > lower.
                state_next = cmp_gt ? ST_CMP_LO : ST_CMP_FLOOR;
            end
            ST_CMP_LO:
            begin
                state_next = cmp_gt ? ST_CMP_HI : ST_IDLE;
            end
            ST_CMP_HI:
            begin
                state_next = cmp_gt ? ST_CMP_FLOOR : ST_IDLE;
            end
            ST_CMP_FLOOR:
            begin
                // Record is consumed even if the floor or strip range rejects it.
                taken_next = 1'b1;
                store_en   = cmp_gt && strip_ok;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    clear_map  = 1'b1;
                    taken_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            taken_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            taken_reg <= taken_next;
        end
    end

    // Config writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= '0;
            upper_bound_reg <= '0;
            use_module_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                sshf_pkg::CFG_LOWER_BOUND: lower_bound_reg <= $signed(cfg.data);
                sshf_pkg::CFG_UPPER_BOUND: upper_bound_reg <= $signed(cfg.data);
                sshf_pkg::CFG_USE_MODULE:  use_module_reg  <= cfg.data[sshf_pkg::MODULE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            strip_reg <= hit_in.strip_id;
            time_reg  <= hit_in.hit_time;
        end
    end

    // Hit map: one flop per strip, cleared at once after the scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_map_reg <= '0;
        end
        else if (clear_map)
        begin
            hit_map_reg <= '0;
        end
        else if (store_en)
        begin
            hit_map_reg[strip_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Time store, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            strip_mem[strip_reg[IDX_W-1:0]] <= time_reg;
        end
        rd_data_reg <= strip_mem[hit_idx_reg];
    end

    // Scan: count hits (saturating at two), remember the last hit strip.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            hit_cnt_reg  <= '0;
            hit_idx_reg  <= '0;
        end
        else if (state_reg == ST_IDLE)
        begin
            scan_idx_reg <= '0;
            hit_cnt_reg  <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (hit_map_reg[scan_idx_reg])
            begin
                hit_cnt_reg <= (hit_cnt_reg == 2'd2) ? 2'd2 : hit_cnt_reg + 2'd1;
                hit_idx_reg <= scan_idx_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_found_reg <= (hit_cnt_reg == 2'd1);
            out_strip_reg <= (hit_cnt_reg == 2'd1) ? sshf_pkg::STRIP_W'(hit_idx_reg) : '0;
            out_time_reg  <= (hit_cnt_reg == 2'd1) ? rd_data_reg : '0;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.found       = out_found_reg;
    assign result_out.found_strip = out_strip_reg;
    assign result_out.found_time  = out_time_reg;

`ifndef SYNTH
    // Hit map is empty right after the end-of-event scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (hit_map_reg == '0))
        else $error("hit map not cleared after scan");

    // Floor step always consumes the record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP_FLOOR) |=> taken_reg)
        else $error("record not consumed after floor compare");

    // A loaded result without a single hit carries zero strip and time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(load_out) && !result_out.found |->
            (result_out.found_strip == '0) && (result_out.found_time == '0))
        else $error("empty result carries data");
`endif

endmodule

[verif/single_strip_hit_finder_unit_tb.sv]
// Self-checking testbench of the single strip hit finder: directed and random hit words.
module single_strip_hit_finder_unit_tb;

    localparam int CHANNELS     = 16;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE_GAP   = 10;    // lets a trailing candidate time word finish
    localparam int WATCHDOG_MAX = 4000;  // cycles with no word moving on any channel
    localparam int PHASE_WORDS  = 400;

    // Index past the register list: the block must drop the write.
    localparam logic [sshf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [sshf_pkg::TIME_W-1:0] T_MIN = 32'h8000_0000;
    localparam logic [sshf_pkg::TIME_W-1:0] T_MAX = 32'h7fff_ffff;

    // func field codes
    localparam logic FN_TIME      = 1'b0;
    localparam logic FN_END_EVENT = 1'b1;

    typedef struct packed {
        logic                                func;
        logic [sshf_pkg::MODULE_W-1:0]       module_id;
        logic [sshf_pkg::STRIP_W-1:0]        strip_id;
        logic                                first_of_channel;
        logic signed [sshf_pkg::TIME_W-1:0]  hit_time;
    } hit_word_t;

    typedef struct packed {
        logic                                found;
        logic [sshf_pkg::STRIP_W-1:0]        found_strip;
        logic signed [sshf_pkg::TIME_W-1:0]  found_time;
    } event_summary_t;

    logic clk;
    logic rst_n;

    sshf_in_if  hit_in();
    sshf_out_if result_out();
    sshf_cfg_if cfg();

    single_strip_hit_finder_unit #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .hit_in     (hit_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: config registers, hit map, time store, record flag
    // ------------------------------------------------------------------
    logic signed [sshf_pkg::TIME_W-1:0]  win_lower;
    logic signed [sshf_pkg::TIME_W-1:0]  win_upper;
    logic [sshf_pkg::MODULE_W-1:0]       sel_module;
    logic [CHANNELS-1:0]                 hit_map;
    logic signed [sshf_pkg::TIME_W-1:0]  strip_time [CHANNELS];
    logic                                record_used;

    event_summary_t            event_summaries [$];

    // Knobs shared by the stimulus tasks and the receiver
    int unsigned in_idle_pct;
    int unsigned out_stall_pct;
    int unsigned hold_req;

    // Run statistics
    int unsigned errors;
    int unsigned words_sent;
    int unsigned events_sent;
    int unsigned summaries_seen;
    int unsigned single_hits_seen;
    int unsigned cfg_writes;

    // Mirrors one accepted hit word; an end of event queues the summary it must produce.
    function automatic void track_strip_hits(hit_word_t w);
        int unsigned    n_hit;
        event_summary_t s;
        s = '0;
        n_hit = 0;
        if (w.func == FN_END_EVENT)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (hit_map[i])
                begin
                    n_hit++;
                    s.found_strip = sshf_pkg::STRIP_W'(i);
                    s.found_time  = strip_time[i];
                end
            end
            hit_map     = '0;
            record_used = 1'b0;
            if (n_hit != 1)
                s = '0;
            else
                s.found = 1'b1;
            event_summaries.push_back(s);
            return;
        end
        if (w.first_of_channel)
            record_used = 1'b0;
        if (w.module_id != sel_module || record_used)
            return;
        // window only applies when upper is strictly above lower
        if (!(win_lower >= win_upper || (w.hit_time > win_lower && w.hit_time < win_upper)))
            return;
        record_used = 1'b1;            // first passing time ends the record even if dropped
        if (w.hit_time <= sshf_pkg::NO_HIT_FLOOR)
            return;
        if (w.strip_id < CHANNELS)
        begin
            hit_map[w.strip_id]    = 1'b1;
            strip_time[w.strip_id] = w.hit_time;
        end
    endfunction

    function automatic hit_word_t make_word(logic fn, int unsigned m, int unsigned s,
                                            logic first, logic [sshf_pkg::TIME_W-1:0] t);
        hit_word_t w;
        w.func             = fn;
        w.module_id        = sshf_pkg::MODULE_W'(m);
        w.strip_id         = sshf_pkg::STRIP_W'(s);
        w.first_of_channel = first;
        w.hit_time         = t;
        return w;
    endfunction

    // Picks a time aimed at the window edges, the floor and the extremes.
    function automatic logic [sshf_pkg::TIME_W-1:0] pick_time();
        longint lo;
        longint hi;
        longint v;
        lo = win_lower;
        hi = win_upper;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom;
            2, 3, 4:
            begin
                if (hi - lo > 1)
                    v = lo + 1 + longint'({$urandom, $urandom} % (hi - lo - 1));
                else
                    v = longint'($urandom_range(0, 200000)) - 100000;
            end
            5:       v = lo;
            6:       v = hi;
            7:       v = longint'(sshf_pkg::NO_HIT_FLOOR) + $urandom_range(0, 2) - 1;
            8:       v = $urandom_range(0, 1) ? longint'(signed'(T_MIN)) : longint'(T_MAX);
            default: v = longint'($urandom_range(0, 200000)) - 100000;
        endcase
        return v[sshf_pkg::TIME_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    // The hold-off is counted here so that no other process drives ready.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_out.ready <= 1'b0;
            end
            else
                result_out.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each summary word against the oldest queued one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        event_summary_t want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            summaries_seen++;
            if (result_out.found)
                single_hits_seen++;
            if (event_summaries.size() == 0)
            begin
                $display("%0t: summary word with none pending: found=%0b strip=%0d time=%h",
                         $time, result_out.found, result_out.found_strip,
                         result_out.found_time);
                errors++;
            end
            else
            begin
                want = event_summaries.pop_front();
                if (result_out.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, result_out.found);
                    errors++;
                end
                if (result_out.found_strip !== want.found_strip)
                begin
                    $display("%0t: found_strip expected %0d actual %0d",
                             $time, want.found_strip, result_out.found_strip);
                    errors++;
                end
                if (result_out.found_time !== want.found_time)
                begin
                    $display("%0t: found_time expected %h actual %h",
                             $time, want.found_time, result_out.found_time);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no word moving anywhere means a hang
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int unsigned quiet;
        if ((hit_in.valid && hit_in.ready) || (result_out.valid && result_out.ready) ||
            (cfg.valid && cfg.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_MAX)
        begin
            $display("%0t: no word moved for %0d cycles, %0d summaries pending",
                     $time, quiet, event_summaries.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Offers one hit word, optionally after a random gap, and waits for it to be taken.
    task automatic send_word(hit_word_t w);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
        begin
            hit_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        hit_in.valid            <= 1'b1;
        hit_in.func             <= w.func;
        hit_in.module_id        <= w.module_id;
        hit_in.strip_id         <= w.strip_id;
        hit_in.first_of_channel <= w.first_of_channel;
        hit_in.hit_time         <= w.hit_time;
        do
            @(posedge clk);
        while (!hit_in.ready);
        track_strip_hits(w);
        words_sent++;
        if (w.func == FN_END_EVENT)
            events_sent++;
    endtask

    task automatic send_time(int unsigned m, int unsigned s, logic first,
                             logic [sshf_pkg::TIME_W-1:0] t);
        send_word(make_word(FN_TIME, m, s, first, t));
    endtask

    // End of event with junk in the ignored fields.
    task automatic end_event();
        send_word(make_word(FN_END_EVENT, $urandom_range(0, 7), $urandom_range(0, 255),
                            1'($urandom_range(0, 1)), $urandom));
    endtask

    // Drop valid, wait for every summary, then let a trailing time word finish.
    task automatic settle();
        hit_in.valid <= 1'b0;
        @(posedge clk);
        while (event_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Caller settles first; the shadow registers follow the write.
    task automatic write_reg(logic [sshf_pkg::CFG_IDX_W-1:0] idx,
                             logic [sshf_pkg::TIME_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        cfg_writes++;
        case (idx)
            sshf_pkg::CFG_LOWER_BOUND: win_lower  = data;
            sshf_pkg::CFG_UPPER_BOUND: win_upper  = data;
            sshf_pkg::CFG_USE_MODULE:  sel_module = data[sshf_pkg::MODULE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_window(logic [sshf_pkg::TIME_W-1:0] lo,
                              logic [sshf_pkg::TIME_W-1:0] hi, int unsigned m);
        settle();
        write_reg(sshf_pkg::CFG_LOWER_BOUND, lo);
        write_reg(sshf_pkg::CFG_UPPER_BOUND, hi);
        write_reg(sshf_pkg::CFG_USE_MODULE, sshf_pkg::TIME_W'(m));
    endtask

    // One event: a few channel records, mostly of the selected module, then its end.
    task automatic send_random_event();
        int unsigned n_rec;
        int unsigned n_times;
        int unsigned m;
        int unsigned s;
        n_rec = $urandom_range(0, 3);
        for (int r = 0; r < n_rec; r++)
        begin
            m = ($urandom_range(0, 9) < 8) ? sel_module : $urandom_range(0, 7);
            s = ($urandom_range(0, 19) < 17) ? $urandom_range(0, CHANNELS - 1)
                                              : $urandom_range(CHANNELS, 255);
            n_times = $urandom_range(1, 3);
            for (int k = 0; k < n_times; k++)
            begin
                if (k == 0)
                    send_time(m, s, $urandom_range(0, 9) != 0, pick_time());
                else
                    send_time(m, s, $urandom_range(0, 19) == 0, pick_time());
            end
        end
        end_event();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Window disabled after reset, module 0: the record rules one by one.
    task automatic test_record_rules();
        end_event();                                    // empty event
        send_time(0, 3, 1'b1, T_MAX);                   // single hit, largest time
        end_event();
        send_time(0, 15, 1'b1, sshf_pkg::NO_HIT_FLOOR); // floor: consumes the record
        send_time(0, 15, 1'b0, 32'd100);                // later time of used record
        send_time(0, 5, 1'b1, sshf_pkg::NO_HIT_FLOOR + 1);  // just above floor
        send_time(0, 6, 1'b1, T_MIN);                   // most negative: below floor
        end_event();
        send_time(1, 2, 1'b1, 32'd5);                   // other module, record stays open
        send_time(0, 2, 1'b0, 32'd6);                   // continues without a start
        end_event();
        send_time(0, CHANNELS, 1'b1, 32'd7);            // out of range strip consumes
        send_time(0, 4, 1'b0, 32'd8);
        send_time(0, 255, 1'b1, 32'd9);
        end_event();
        send_time(0, 1, 1'b1, 32'd10);                  // two strips: nothing found
        send_time(0, 9, 1'b1, 32'd11);
        end_event();
        send_time(0, 7, 1'b1, 32'd12);                  // same strip again overwrites
        send_time(0, 7, 1'b1, 32'hffff_ff00);
        send_word(make_word(FN_END_EVENT, 7, 255, 1'b1, T_MIN));
    endtask

    // Window edges are exclusive; equal and inverted bounds disable it.
    task automatic test_window();
        set_window(32'd100, 32'd200, 6);
        send_time(6, 0, 1'b1, 32'd100);                 // at lower: outside
        send_time(6, 0, 1'b0, 32'd200);                 // at upper: outside
        send_time(6, 0, 1'b0, 32'd150);
        send_time(6, 0, 1'b0, 32'd160);                 // record already used
        end_event();
        settle();
        write_reg(CFG_UNUSED, 32'hffff_ffff);           // must change nothing
        send_time(6, 11, 1'b1, 32'd99);
        send_time(6, 12, 1'b1, 32'd101);
        end_event();
        set_window(T_MAX, T_MIN, 7);                    // inverted: all pass
        send_time(7, 8, 1'b1, T_MIN);
        send_time(7, 13, 1'b1, T_MAX);
        end_event();
        set_window(32'hffff_fffb, 32'hffff_fffb, 7);    // equal: all pass
        send_time(7, 14, 1'b1, 32'hffff_fffb);
        end_event();
        set_window(T_MIN, T_MAX, 3);                    // widest enabled window
        send_time(3, 10, 1'b1, T_MIN);
        send_time(3, 10, 1'b0, T_MAX);
        send_time(3, 10, 1'b0, 32'd0);
        end_event();
    endtask

    // Random config and random events under one idling pattern.
    task automatic test_random_phase(int unsigned in_pct, int unsigned out_pct);
        int unsigned stop_at;
        longint      lo;
        longint      hi;
        case ($urandom_range(0, 4))
            0:
            begin
                lo = signed'(32'($urandom));
                hi = lo;
            end
            1:
            begin
                lo = signed'(32'($urandom));
                hi = signed'(32'($urandom));
            end
            2:
            begin
                lo = -longint'($urandom_range(0, 50000));
                hi = $urandom_range(1, 50000);
            end
            3:
            begin
                lo = signed'(T_MIN);
                hi = T_MAX;
            end
            default:
            begin
                lo = longint'(sshf_pkg::NO_HIT_FLOOR) - $urandom_range(0, 1000);
                hi = $urandom_range(0, 100000);
            end
        endcase
        set_window(lo[sshf_pkg::TIME_W-1:0], hi[sshf_pkg::TIME_W-1:0], $urandom_range(0, 7));
        if ($urandom_range(0, 1))
            write_reg(CFG_UNUSED, $urandom);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        stop_at = words_sent + PHASE_WORDS;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 8)
                send_time($urandom_range(0, 7), $urandom_range(0, 255),
                          1'($urandom_range(0, 1)), $urandom);    // noise word
            else
                send_random_event();
        end
        settle();
    endtask

    // Receiver holds off while events keep coming, so the input must stall;
    // then the sender waits for every summary.
    task automatic test_backpressure();
        set_window(32'd0, 32'd0, 2);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req++;
        for (int e = 0; e < 12; e++)
        begin
            send_time(2, e, 1'b1, $urandom);
            send_time(2, e + 1, 1'($urandom_range(0, 1)), $urandom);
            end_event();
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors           = 0;
        words_sent       = 0;
        events_sent      = 0;
        summaries_seen   = 0;
        single_hits_seen = 0;
        cfg_writes       = 0;
        in_idle_pct      = 0;
        out_stall_pct    = 0;
        hold_req         = 0;
        win_lower        = '0;
        win_upper        = '0;
        sel_module       = '0;
        hit_map          = '0;
        record_used      = 1'b0;

        hit_in.valid            = 1'b0;
        hit_in.func             = FN_TIME;
        hit_in.module_id        = '0;
        hit_in.strip_id         = '0;
        hit_in.first_of_channel = 1'b0;
        hit_in.hit_time         = '0;
        cfg.valid               = 1'b0;
        cfg.index               = sshf_pkg::CFG_LOWER_BOUND;
        cfg.data                = '0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_record_rules();
        test_window();
        test_random_phase(0, 0);
        test_random_phase(56, 0);
        test_backpressure();
        test_random_phase(0, 56);
        test_random_phase(32, 32);

        // Drain, then give a last end-of-event scan time to show up stray words.
        settle();
        repeat (CHANNELS + 8) @(posedge clk);
        if (event_summaries.size() != 0)
        begin
            $display("%0t: %0d summaries never arrived", $time, event_summaries.size());
            errors++;
        end

        $display("Sent %0d hit words in %0d events over %0d config writes;",
                 words_sent, events_sent, cfg_writes);
        $display("checked %0d summaries, %0d with a single strip, %0d mismatches.",
                 summaries_seen, single_hits_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
